>>> rtl/core/quad_x_motor_mixer_assert.svh
// assertion macros shared by the mixer rtl
// define ASSERT_OFF to drop every check
`ifndef QUAD_X_MOTOR_MIXER_ASSERT_SVH
`define QUAD_X_MOTOR_MIXER_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define QXMM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define QXMM_ASSERT_NEVER(name, clk, rstn, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define QXMM_ASSERT(name, clk, rstn, prop, msg)
`define QXMM_ASSERT_NEVER(name, clk, rstn, expr, msg)

`endif

`endif

>>> rtl/core/qxmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qxmm_pkg;

    // fraction bits of the command format, 1.0 = 2^FRAC_BITS
    localparam int FRAC_BITS  = 15;
    localparam int DATA_W     = 16;
    localparam int NUM_MOTORS = 4;

    // working levels in units of 2^-(FRAC_BITS+1), signed
    localparam int LEVEL_W = (FRAC_BITS + 3 > 21) ? FRAC_BITS + 3 : 21;
    // clamped level, 0 .. 2^(FRAC_BITS+1)
    localparam int LVL_W   = FRAC_BITS + 2;
    localparam int PROD_W  = LVL_W + DATA_W;

    localparam int CFG_IDX_W = 1;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [LVL_W-1:0]          clamp_t;
    typedef logic [DATA_W-1:0]         word_t;
    typedef logic [PROD_W-1:0]         prod_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    localparam cfg_idx_t REG_PWM_MIN = 1'b0;
    localparam cfg_idx_t REG_PWM_MAX = 1'b1;

    localparam word_t PWM_MIN_RESET = 16'd1000;
    localparam word_t PWM_MAX_RESET = 16'd2000;

    localparam level_t FULL_LEVEL = level_t'(longint'(1) << (FRAC_BITS + 1));
    localparam clamp_t FULL_CLAMP = clamp_t'(longint'(1) << (FRAC_BITS + 1));

    // clamped motor levels moving from the mixer to the scaler
    typedef struct packed {
        logic                             valid;
        logic [NUM_MOTORS-1:0][LVL_W-1:0] level;
    } lvl_bus_t;

endpackage

`default_nettype wire

>>> rtl/core/qxmm_if.sv
`timescale 1ns / 1ps
`default_nettype none

// command set channel
interface qxmm_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic        [qxmm_pkg::DATA_W-1:0]   throttle;
    logic signed [qxmm_pkg::DATA_W-1:0]   roll_cmd;
    logic signed [qxmm_pkg::DATA_W-1:0]   pitch_cmd;
    logic signed [qxmm_pkg::DATA_W-1:0]   yaw_cmd;

    modport source (output valid, throttle, roll_cmd, pitch_cmd, yaw_cmd, input ready);
    modport sink   (input valid, throttle, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

// pwm compare value channel
interface qxmm_pwm_if;
    logic                          valid;
    logic                          ready;
    logic [qxmm_pkg::DATA_W-1:0]   front_left_pwm;
    logic [qxmm_pkg::DATA_W-1:0]   front_right_pwm;
    logic [qxmm_pkg::DATA_W-1:0]   rear_right_pwm;
    logic [qxmm_pkg::DATA_W-1:0]   rear_left_pwm;

    modport source (output valid, front_left_pwm, front_right_pwm, rear_right_pwm,
                    rear_left_pwm, input ready);
    modport sink   (input valid, front_left_pwm, front_right_pwm, rear_right_pwm,
                    rear_left_pwm, output ready);
endinterface

// register write channel
interface qxmm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qxmm_pkg::CFG_IDX_W-1:0]   index;
    logic [qxmm_pkg::DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qxmm_mix.sv
`timescale 1ns / 1ps
`default_nettype none
`include "quad_x_motor_mixer_assert.svh"

// mix, find extremes, desaturate, clamp: four register stages
module qxmm_mix (
    input  logic               clk,
    input  logic               rst_n,
    qxmm_cmd_if.sink           cmd,
    output qxmm_pkg::lvl_bus_t lvl_out,
    input  logic               lvl_ready
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    qxmm_pkg::level_t lv_next  [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::level_t lv1_reg  [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::level_t lv2_reg  [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::level_t lv3_reg  [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::clamp_t clamp_next [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::clamp_t clamp4_reg [qxmm_pkg::NUM_MOTORS];

    qxmm_pkg::level_t t_ext, r_ext, p_ext, y_ext;
    qxmm_pkg::level_t hi_a, hi_b, lo_a, lo_b, hi_next, lo_next;
    qxmm_pkg::level_t hi2_reg, lo2_reg;
    qxmm_pkg::level_t excess, lo_shift, deficit, off_next, off3_reg;
    qxmm_pkg::level_t sum [qxmm_pkg::NUM_MOTORS];

    // a stage moves when empty or when the stage after it moves
    always_comb
    begin
        adv[STAGES] = lvl_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign cmd.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= cmd.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: x-frame mix, throttle doubled so halved attitude terms stay exact
    always_comb
    begin
        t_ext = qxmm_pkg::level_t'({cmd.throttle, 1'b0});
        r_ext = qxmm_pkg::level_t'(cmd.roll_cmd);
        p_ext = qxmm_pkg::level_t'(cmd.pitch_cmd);
        y_ext = qxmm_pkg::level_t'(cmd.yaw_cmd);
        lv_next[0] = t_ext + r_ext - p_ext + y_ext;
        lv_next[1] = t_ext - r_ext - p_ext - y_ext;
        lv_next[2] = t_ext - r_ext + p_ext + y_ext;
        lv_next[3] = t_ext + r_ext + p_ext - y_ext;
    end

    // stage 2: highest and lowest level
    always_comb
    begin
        hi_a    = (lv1_reg[1] > lv1_reg[0]) ? lv1_reg[1] : lv1_reg[0];
        hi_b    = (lv1_reg[3] > lv1_reg[2]) ? lv1_reg[3] : lv1_reg[2];
        lo_a    = (lv1_reg[1] < lv1_reg[0]) ? lv1_reg[1] : lv1_reg[0];
        lo_b    = (lv1_reg[3] < lv1_reg[2]) ? lv1_reg[3] : lv1_reg[2];
        hi_next = (hi_b > hi_a) ? hi_b : hi_a;
        lo_next = (lo_b < lo_a) ? lo_b : lo_a;
    end

    // stage 3: common shift, lower by the excess then raise by the deficit
    always_comb
    begin
        excess   = (hi2_reg > qxmm_pkg::FULL_LEVEL) ? hi2_reg - qxmm_pkg::FULL_LEVEL : '0;
        lo_shift = lo2_reg - excess;
        deficit  = (lo_shift < 0) ? -lo_shift : '0;
        off_next = deficit - excess;
    end

    // stage 4: apply shift and clamp to [0, 1.0]
    always_comb
    begin
        for (int m = 0; m < qxmm_pkg::NUM_MOTORS; m++)
        begin
            sum[m] = lv3_reg[m] + off3_reg;
            if (sum[m] < 0)
            begin
                clamp_next[m] = '0;
            end
            else if (sum[m] > qxmm_pkg::FULL_LEVEL)
            begin
                clamp_next[m] = qxmm_pkg::FULL_CLAMP;
            end
            else
            begin
                clamp_next[m] = sum[m][qxmm_pkg::LVL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            lv1_reg <= lv_next;
        end
        if (adv[1])
        begin
            lv2_reg <= lv1_reg;
            hi2_reg <= hi_next;
            lo2_reg <= lo_next;
        end
        if (adv[2])
        begin
            lv3_reg  <= lv2_reg;
            off3_reg <= off_next;
        end
        if (adv[3])
        begin
            clamp4_reg <= clamp_next;
        end
    end

    always_comb
    begin
        lvl_out.valid = valid_reg[STAGES-1];
        for (int m = 0; m < qxmm_pkg::NUM_MOTORS; m++)
        begin
            lvl_out.level[m] = clamp4_reg[m];
        end
    end

    `QXMM_ASSERT(a_mix_stall_hold, clk, rst_n, lvl_out.valid && !lvl_ready |=> lvl_out.valid, "mixer dropped a stalled level set")
    `QXMM_ASSERT_NEVER(a_mix_clamp_range, clk, rst_n, lvl_out.valid && (clamp4_reg[0] > qxmm_pkg::FULL_CLAMP || clamp4_reg[1] > qxmm_pkg::FULL_CLAMP || clamp4_reg[2] > qxmm_pkg::FULL_CLAMP || clamp4_reg[3] > qxmm_pkg::FULL_CLAMP), "clamped level above full scale")
    `QXMM_ASSERT(a_mix_desat, clk, rst_n, valid_reg[1] |-> (hi2_reg + off_next <= qxmm_pkg::FULL_LEVEL) || (lo2_reg + off_next == 0), "desaturation left top above full and bottom off zero")

endmodule

`default_nettype wire

>>> rtl/core/qxmm_scale.sv
`timescale 1ns / 1ps
`default_nettype none

// level to compare value: multiply stage, then offset stage
module qxmm_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  qxmm_pkg::lvl_bus_t lvl_in,
    output logic               lvl_ready,
    input  qxmm_pkg::word_t    pwm_min,
    input  qxmm_pkg::word_t    pwm_range,
    qxmm_pwm_if.source         pwm
);

    localparam int STAGES = 2;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    qxmm_pkg::prod_t prod_next [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::prod_t prod_reg  [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::word_t out_next  [qxmm_pkg::NUM_MOTORS];
    qxmm_pkg::word_t out_reg   [qxmm_pkg::NUM_MOTORS];

    always_comb
    begin
        adv[STAGES] = pwm.ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign lvl_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= lvl_in.valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_comb
    begin
        for (int m = 0; m < qxmm_pkg::NUM_MOTORS; m++)
        begin
            prod_next[m] = qxmm_pkg::prod_t'(lvl_in.level[m]) * qxmm_pkg::prod_t'(pwm_range);
            // drop the level fraction, wrap to 16 bits
            out_next[m]  = pwm_min + prod_reg[m][qxmm_pkg::FRAC_BITS+1 +: qxmm_pkg::DATA_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
        end
        if (adv[1])
        begin
            out_reg <= out_next;
        end
    end

    assign pwm.valid           = valid_reg[STAGES-1];
    assign pwm.front_left_pwm  = out_reg[0];
    assign pwm.front_right_pwm = out_reg[1];
    assign pwm.rear_right_pwm  = out_reg[2];
    assign pwm.rear_left_pwm   = out_reg[3];

endmodule

`default_nettype wire

>>> rtl/core/quad_x_motor_mixer.sv
// quad x-frame motor mixer with desaturation
// cmd: one command set per transfer (throttle, roll, pitch, yaw, q1.15)
// pwm: four compare values per transfer, one result for every command set
// cfg: register writes, index 0 = pwm_min, index 1 = pwm_max; always ready,
//   write only while no command set is in flight
// pipeline: six registers deep (mix, min/max, shift, clamp, multiply, offset);
//   the first loads on the cmd transfer edge, the last drives the pwm channel
// throughput: one command set per cycle while pwm.ready is high; every stage moves
//   when it is empty or the stage after it moves, so the pipe stays full end to end
// stall: with pwm.ready low the result holds and the stages behind it
//   fill; cmd.ready drops only once all six stages hold a set
// reset: pipeline empty, pwm_min = 1000, pwm_max = 2000
// pwm_max below pwm_min gives a zero range: every output is pwm_min
`timescale 1ns / 1ps
`default_nettype none
`include "quad_x_motor_mixer_assert.svh"

module quad_x_motor_mixer (
    input  logic        clk,
    input  logic        rst_n,
    qxmm_cmd_if.sink    cmd,
    qxmm_pwm_if.source  pwm,
    qxmm_cfg_if.sink    cfg
);

    qxmm_pkg::word_t pwm_min_reg, pwm_min_next;
    qxmm_pkg::word_t pwm_max_reg, pwm_max_next;
    qxmm_pkg::word_t range_reg, range_next;

    qxmm_pkg::lvl_bus_t lvl_bus;
    logic               lvl_ready;

    // register writes never stall
    assign cfg.ready = 1'b1;

    always_comb
    begin
        pwm_min_next = pwm_min_reg;
        pwm_max_next = pwm_max_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                qxmm_pkg::REG_PWM_MIN: pwm_min_next = cfg.data;
                qxmm_pkg::REG_PWM_MAX: pwm_max_next = cfg.data;
                default: ;
            endcase
        end
    end

    // range settles behind the limit registers, before a new set reaches the multiplier
    assign range_next = (pwm_max_reg >= pwm_min_reg) ? pwm_max_reg - pwm_min_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_min_reg <= qxmm_pkg::PWM_MIN_RESET;
            pwm_max_reg <= qxmm_pkg::PWM_MAX_RESET;
            range_reg   <= qxmm_pkg::PWM_MAX_RESET - qxmm_pkg::PWM_MIN_RESET;
        end
        else
        begin
            pwm_min_reg <= pwm_min_next;
            pwm_max_reg <= pwm_max_next;
            range_reg   <= range_next;
        end
    end

    // mixing, desaturation and clamp
    qxmm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .lvl_out   (lvl_bus),
        .lvl_ready (lvl_ready)
    );

    // level times range plus pwm_min, output register
    qxmm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .lvl_in    (lvl_bus),
        .lvl_ready (lvl_ready),
        .pwm_min   (pwm_min_reg),
        .pwm_range (range_reg),
        .pwm       (pwm)
    );

    `QXMM_ASSERT(a_top_range_zero, clk, rst_n,
        (pwm_max_reg < pwm_min_reg) |=> (range_reg == 0),
        "inverted limits gave a nonzero range")
    `QXMM_ASSERT(a_top_range_diff, clk, rst_n,
        (pwm_max_reg >= pwm_min_reg) |=>
            (range_reg == $past(pwm_max_reg) - $past(pwm_min_reg)),
        "range does not match the limits")
    `QXMM_ASSERT(a_top_ready_empty, clk, rst_n,
        !pwm.valid |-> cmd.ready,
        "command input stalled with no result waiting")

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    // watchdog on the whole run, far above the slowest legal run
    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 104;
    localparam int NUM_DIRECTED = 18;

    // one command set as it crosses the cmd channel
    typedef struct packed {
        qxmm_pkg::word_t throttle;
        qxmm_pkg::word_t roll;
        qxmm_pkg::word_t pitch;
        qxmm_pkg::word_t yaw;
    } cmd_set_t;

    // four compare values, one per motor
    typedef struct packed {
        qxmm_pkg::word_t fl;
        qxmm_pkg::word_t fr;
        qxmm_pkg::word_t rr;
        qxmm_pkg::word_t rl;
    } pwm_set_t;

    // directed row: command set, and a hand-typed answer where chk is set
    typedef struct packed {
        cmd_set_t cmd;
        bit       chk;
        pwm_set_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    qxmm_cmd_if cmd_ch ();
    qxmm_pwm_if pwm_ch ();
    qxmm_cfg_if cfg_ch ();

    quad_x_motor_mixer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pwm   (pwm_ch),
        .cfg   (cfg_ch)
    );

    // register copies used for prediction, updated on every cfg transfer
    qxmm_pkg::word_t cur_pwm_min = qxmm_pkg::PWM_MIN_RESET;
    qxmm_pkg::word_t cur_pwm_max = qxmm_pkg::PWM_MAX_RESET;

    // compare values still owed by the block, oldest first
    pwm_set_t pwm_expect_q [$];

    int       err_count = 0;
    int       cycle_count = 0;
    bit       src_gaps = 1'b1;
    bit       sink_stalls = 1'b1;

    // directed rows: answers typed in only for the obvious ones at the
    // reset range 1000..2000
    dir_row_t dir_tbl [0:NUM_DIRECTED-1] = '{
        // all zero: every motor at pwm_min
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{16'd1000, 16'd1000, 16'd1000, 16'd1000}},
        // full throttle: every motor at pwm_max
        '{'{16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{16'd2000, 16'd2000, 16'd2000, 16'd2000}},
        // half throttle: midpoint
        '{'{16'h4000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{16'd1500, 16'd1500, 16'd1500, 16'd1500}},
        // throttle above 1.0 is pulled back to full
        '{'{16'hffff, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{16'd2000, 16'd2000, 16'd2000, 16'd2000}},
        // hard left roll at zero throttle, lifted by the deficit
        '{'{16'h0000, 16'h8000, 16'h0000, 16'h0000}, 1'b1,
          '{16'd1000, 16'd2000, 16'd2000, 16'd1000}},
        // hard counter-clockwise yaw at zero throttle
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h8000}, 1'b1,
          '{16'd1000, 16'd2000, 16'd1000, 16'd2000}},
        '{'{16'h0000, 16'h7fff, 16'h0000, 16'h0000}, 1'b0, '0},
        '{'{16'h4000, 16'h0000, 16'h8000, 16'h0000}, 1'b0, '0},
        '{'{16'h4000, 16'h0000, 16'h7fff, 16'h0000}, 1'b0, '0},
        '{'{16'h4000, 16'h0000, 16'h0000, 16'h7fff}, 1'b0, '0},
        '{'{16'h8000, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, '0},
        '{'{16'h0000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{'{16'hffff, 16'h8000, 16'h7fff, 16'h8000}, 1'b0, '0},
        // spread wider than 1.0: still clamped after both shifts
        '{'{16'h4000, 16'h7fff, 16'h8000, 16'h7fff}, 1'b0, '0},
        // mild mix, nothing saturates
        '{'{16'h4000, 16'h0800, 16'hfc00, 16'h0200}, 1'b0, '0},
        // neither shift applies, the top stays below full
        '{'{16'h7000, 16'h1000, 16'h1000, 16'h1000}, 1'b0, '0},
        // only the deficit shift applies
        '{'{16'h0800, 16'hf000, 16'h0400, 16'h0000}, 1'b0, '0},
        '{'{16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b0, '0}
    };

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mix, desaturate, clamp and scale one command set with the current
    // register copies; levels are in units of 2^-(FRAC_BITS+1)
    function automatic pwm_set_t mix_motors(cmd_set_t c);
        longint          full;
        longint          thr2;
        longint          r;
        longint          p;
        longint          y;
        longint          hi;
        longint          lo;
        longint          span;
        longint          v;
        longint          lvl [4];
        qxmm_pkg::word_t outw [4];
        pwm_set_t        res;
        full = longint'(1) << (qxmm_pkg::FRAC_BITS + 1);
        thr2 = longint'(c.throttle) * 2;
        r    = longint'($signed(c.roll));
        p    = longint'($signed(c.pitch));
        y    = longint'($signed(c.yaw));
        lvl[0] = thr2 + r - p + y;
        lvl[1] = thr2 - r - p - y;
        lvl[2] = thr2 - r + p + y;
        lvl[3] = thr2 + r + p - y;
        hi = lvl[0];
        lo = lvl[0];
        for (int i = 1; i < 4; i++)
        begin
            if (lvl[i] < lo) lo = lvl[i];
            if (lvl[i] > hi) hi = lvl[i];
        end
        // pull the top motor down to full, then lift the bottom one to zero
        if (hi > full)
        begin
            for (int i = 0; i < 4; i++) lvl[i] -= hi - full;
            lo -= hi - full;
        end
        if (lo < 0)
        begin
            for (int i = 0; i < 4; i++) lvl[i] -= lo;
        end
        // inverted register pair means no range at all
        span = (cur_pwm_max >= cur_pwm_min) ?
               longint'(cur_pwm_max) - longint'(cur_pwm_min) : 0;
        for (int i = 0; i < 4; i++)
        begin
            v = lvl[i];
            if (v < 0) v = 0;
            if (v > full) v = full;
            outw[i] = qxmm_pkg::word_t'(longint'(cur_pwm_min) +
                      ((v * span) >> (qxmm_pkg::FRAC_BITS + 1)));
        end
        res.fl = outw[0];
        res.fr = outw[1];
        res.rr = outw[2];
        res.rl = outw[3];
        return res;
    endfunction

    // random command set, biased toward sets that mix without clamping
    function automatic cmd_set_t random_cmd();
        cmd_set_t        c;
        qxmm_pkg::word_t edges [4];
        int              kind;
        edges = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff};
        kind  = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3:
            begin
                // moderate attitude terms over throttle from zero to 1.0
                c.throttle = qxmm_pkg::word_t'($urandom_range(0, 32768));
                c.roll     = qxmm_pkg::word_t'($urandom_range(0, 16383) - 8192);
                c.pitch    = qxmm_pkg::word_t'($urandom_range(0, 16383) - 8192);
                c.yaw      = qxmm_pkg::word_t'($urandom_range(0, 16383) - 8192);
            end
            4, 5, 6:
            begin
                c.throttle = qxmm_pkg::word_t'($urandom_range(0, 32768));
                c.roll     = qxmm_pkg::word_t'($urandom);
                c.pitch    = qxmm_pkg::word_t'($urandom);
                c.yaw      = qxmm_pkg::word_t'($urandom);
            end
            7:
            begin
                // whole field width, throttle above 1.0 included
                c = cmd_set_t'({$urandom, $urandom});
            end
            8:
            begin
                c.throttle = edges[$urandom_range(0, 3)];
                c.roll     = edges[$urandom_range(0, 3)];
                c.pitch    = edges[$urandom_range(0, 3)];
                c.yaw      = edges[$urandom_range(0, 3)];
            end
            default:
            begin
                // near hover with small corrections
                c.throttle = qxmm_pkg::word_t'($urandom_range(14000, 19000));
                c.roll     = qxmm_pkg::word_t'($urandom_range(0, 1023) - 512);
                c.pitch    = qxmm_pkg::word_t'($urandom_range(0, 1023) - 512);
                c.yaw      = qxmm_pkg::word_t'($urandom_range(0, 1023) - 512);
            end
        endcase
        return c;
    endfunction

    // one cmd transfer; valid stays high into the next set unless a gap
    // is taken, and the expectation is queued at the accepting edge
    task automatic send_cmd(input cmd_set_t c, input pwm_set_t want);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.throttle  <= c.throttle;
        cmd_ch.roll_cmd  <= c.roll;
        cmd_ch.pitch_cmd <= c.pitch;
        cmd_ch.yaw_cmd   <= c.yaw;
        do @(posedge clk); while (!cmd_ch.ready);
        pwm_expect_q.push_back(want);
    endtask

    // close the command stream and wait until every result is back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pwm_expect_q.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // write both registers back to back, block idle
    task automatic write_range(input qxmm_pkg::word_t lo_val, input qxmm_pkg::word_t hi_val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= qxmm_pkg::REG_PWM_MIN;
        cfg_ch.data  <= lo_val;
        do @(posedge clk); while (!cfg_ch.ready);
        cur_pwm_min = lo_val;
        cfg_ch.index <= qxmm_pkg::REG_PWM_MAX;
        cfg_ch.data  <= hi_val;
        do @(posedge clk); while (!cfg_ch.ready);
        cur_pwm_max = hi_val;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void check_word(string what, qxmm_pkg::word_t want,
                                       qxmm_pkg::word_t got);
        if (want !== got)
        begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // result side: every pwm transfer must match the oldest expectation
    always @(posedge clk)
    begin : pwm_check
        pwm_set_t want;
        if (rst_n && pwm_ch.valid && pwm_ch.ready)
        begin
            if (pwm_expect_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected pwm transfer: %0d %0d %0d %0d",
                             pwm_ch.front_left_pwm, pwm_ch.front_right_pwm,
                             pwm_ch.rear_right_pwm, pwm_ch.rear_left_pwm);
            end
            else
            begin
                want = pwm_expect_q.pop_front();
                check_word("front_left_pwm", want.fl, pwm_ch.front_left_pwm);
                check_word("front_right_pwm", want.fr, pwm_ch.front_right_pwm);
                check_word("rear_right_pwm", want.rr, pwm_ch.rear_right_pwm);
                check_word("rear_left_pwm", want.rl, pwm_ch.rear_left_pwm);
            end
        end
    end

    // result backpressure: ready bursts broken by stalls while sink_stalls is set
    initial
    begin : pwm_sink
        forever
        begin
            pwm_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (sink_stalls)
            begin
                pwm_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        cmd_set_t        c;
        qxmm_pkg::word_t phase_min [NUM_PHASES];
        qxmm_pkg::word_t phase_max [NUM_PHASES];
        qxmm_pkg::word_t ra;
        qxmm_pkg::word_t rb;
        bit              quiet;

        // every input known from time zero
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.throttle  <= '0;
        cmd_ch.roll_cmd  <= '0;
        cmd_ch.pitch_cmd <= '0;
        cmd_ch.yaw_cmd   <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= qxmm_pkg::REG_PWM_MIN;
        cfg_ch.data      <= '0;

        // register settings per phase: full span, inverted, both extremes equal,
        // inverted end to end, random pairs, one-count span, and back to reset values
        ra = qxmm_pkg::word_t'($urandom);
        rb = qxmm_pkg::word_t'($urandom);
        phase_min = '{16'd0, 16'd5000, 16'hffff, 16'd0, 16'hffff,
                      16'd0, 16'd0, 16'd0, 16'd1000};
        phase_max = '{16'hffff, 16'd100, 16'hffff, 16'd0, 16'd0,
                      16'd0, 16'd0, 16'd1, 16'd2000};
        phase_min[5] = qxmm_pkg::word_t'($urandom);
        phase_max[5] = qxmm_pkg::word_t'($urandom);
        phase_min[6] = (ra < rb) ? ra : rb;
        phase_max[6] = (ra < rb) ? rb : ra;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset range
        foreach (dir_tbl[i])
        begin
            c = dir_tbl[i].cmd;
            send_cmd(c, dir_tbl[i].chk ? dir_tbl[i].want : mix_motors(c));
        end

        // random sets at the reset range
        for (int n = 0; n < 100; n++)
        begin
            c = random_cmd();
            send_cmd(c, mix_motors(c));
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_range(phase_min[ph], phase_max[ph]);
            quiet = (ph == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // idling comes and goes in stretches, none in the last phase
                if (n % 32 == 0)
                begin
                    src_gaps    = !quiet && ($urandom_range(0, 2) != 0);
                    sink_stalls = !quiet && ($urandom_range(0, 2) != 0);
                end
                c = random_cmd();
                send_cmd(c, mix_motors(c));
            end
            drain();
        end

        // wait past the pipeline depth to catch stray results
        repeat (12) @(posedge clk);
        if (pwm_expect_q.size() != 0) err_count++;

        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/qxmm_pkg.sv
rtl/core/qxmm_if.sv
rtl/core/qxmm_mix.sv
rtl/core/qxmm_scale.sv
rtl/core/quad_x_motor_mixer.sv
sim/tb.sv
